// ===== rtl/homogeneous_point_transform_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the homogeneous point transform unit
// Shared implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_POINT_TRANSFORM_UNIT_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_UNIT_MACROS_SVH

// Same-cycle implication, inactive during reset
`define HPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hpt assertion failed");

// Next-cycle implication, inactive during reset
`define HPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hpt assertion failed");

// Next-cycle implication, also checked across reset
`define HPT_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hpt assertion failed");

`endif

// ===== rtl/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hpt_pkg
// Types and constants shared by the homogeneous point transform unit.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int DATA_W        = 32;
    localparam int ACC_W         = 48;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int FIFO_DEPTH    = 4;

    typedef logic [DATA_W-1:0] t_word;
    typedef t_word [3:0][3:0]  t_mat;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_WZERO = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    // One queued point with its vector form
    typedef struct packed {
        logic  op;
        t_word x;
        t_word y;
        t_word z;
    } t_item;

endpackage

// ===== rtl/hpt_front.sv =====
// ----------------------------------------------------------------------------
// hpt_front
// Input side: accepts point beats and queues them for the arithmetic back end.
// ----------------------------------------------------------------------------
module hpt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  hpt_pkg::t_item i_item,
    input  logic          i_pop,
    output logic          o_avail,
    output hpt_pkg::t_item o_item
);
    import hpt_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_item             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]    r_count;
    logic              push, pop;

    assign o_stall = (r_count == (PTR_W+1)'(FIFO_DEPTH));
    assign o_avail = (r_count != '0);
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && o_avail;
    assign o_item  = r_mem[r_rd_ptr];

    // Store accepted beats
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (push && !pop)      r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

endmodule

// ===== rtl/hpt_div.sv =====
// ----------------------------------------------------------------------------
// hpt_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module hpt_div #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [hpt_pkg::ACC_W-1:0] i_num,
    input  logic signed [hpt_pkg::ACC_W-1:0] i_den,
    output logic [hpt_pkg::DATA_W-1:0]     o_quot,
    output logic                           o_sat
);
    import hpt_pkg::*;

    localparam int NB = ACC_W + FRAC_BITS;

    logic [ACC_W-1:0]  r_rem [NB+1];
    logic [NB-1:0]     r_dvd [NB+1];
    logic [ACC_W-1:0]  r_d   [NB+1];
    logic [DATA_W-1:0] r_q   [NB+1];
    logic              r_hi  [NB+1];
    logic              r_neg [NB+1];

    logic [ACC_W-1:0]  n_rem [NB];
    logic [DATA_W-1:0] n_q   [NB];
    logic              n_hi  [NB];

    logic [ACC_W-1:0]  abs_num, abs_den;
    logic [DATA_W-1:0] limit, q_sel;
    logic              big;

    assign abs_num = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
    assign abs_den = i_den[ACC_W-1] ? ACC_W'(-i_den) : ACC_W'(i_den);

    // One compare and subtract per stage
    always_comb begin
        logic [ACC_W:0] t;
        logic           ge;
        for (int s = 0; s < NB; s++) begin
            t        = {r_rem[s], r_dvd[s][NB-1]};
            ge       = (t >= {1'b0, r_d[s]});
            n_rem[s] = ge ? ACC_W'(t - {1'b0, r_d[s]}) : t[ACC_W-1:0];
            n_q[s]   = {r_q[s][DATA_W-2:0], ge};
            n_hi[s]  = r_hi[s] | r_q[s][DATA_W-1];
        end
    end

    // Load the first stage and advance the rest
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_dvd[0] <= {abs_num, FRAC_BITS'(0)};
            r_d[0]   <= abs_den;
            r_q[0]   <= '0;
            r_hi[0]  <= 1'b0;
            r_neg[0] <= i_num[ACC_W-1] ^ i_den[ACC_W-1];
            for (int s = 0; s < NB; s++) begin
                r_rem[s+1] <= n_rem[s];
                r_dvd[s+1] <= {r_dvd[s][NB-2:0], 1'b0};
                r_d[s+1]   <= r_d[s];
                r_q[s+1]   <= n_q[s];
                r_hi[s+1]  <= n_hi[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    // Clamp to the signed range and apply the sign
    assign limit  = r_neg[NB] ? {1'b1, (DATA_W-1)'(0)} : {1'b0, {(DATA_W-1){1'b1}}};
    assign big    = r_hi[NB] || (r_q[NB] > limit);
    assign q_sel  = big ? limit : r_q[NB];
    assign o_quot = r_neg[NB] ? DATA_W'(-q_sel) : q_sel;
    assign o_sat  = big;

endmodule

// ===== rtl/hpt_back.sv =====
// ----------------------------------------------------------------------------
// hpt_back
// Arithmetic back end: matrix products, 48-bit sums, divides, result register.
// ----------------------------------------------------------------------------
module hpt_back #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hpt_pkg::t_mat               i_mat,
    input  logic                        i_avail,
    input  hpt_pkg::t_item              i_item,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [hpt_pkg::DATA_W-1:0]  o_out_x,
    output logic [hpt_pkg::DATA_W-1:0]  o_out_y,
    output logic [hpt_pkg::DATA_W-1:0]  o_out_z,
    output logic [1:0]                  o_status
);
    import hpt_pkg::*;

    localparam int NB  = ACC_W + FRAC_BITS;
    localparam int EXT = ACC_W - DATA_W;

    logic                      en;
    logic                      r_p1_valid, r_p2_valid;
    logic signed [2*DATA_W-1:0] r_prod [4][3];
    logic [DATA_W-1:0]         r_tr [4];
    logic [ACC_W-1:0]          r_acc [4];
    logic                      r_vd [NB+1];
    logic                      r_wz [NB+1];
    logic [DATA_W-1:0]         quot [3];
    logic                      sat  [3];
    logic                      r_out_valid;
    logic [DATA_W-1:0]         r_out [3];
    t_status                   r_status;
    t_word                     pt [3];

    // Whole pipe moves unless a held result is stalled
    assign en    = !(r_out_valid && i_stall);
    assign o_pop = en;
    assign pt[0] = i_item.x;
    assign pt[1] = i_item.y;
    assign pt[2] = i_item.z;

    // Select entries by vector form and multiply
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[j][k] <= $signed(i_item.op ? i_mat[j][k] : i_mat[k][j])
                                  * $signed(pt[k]);
                end
                r_tr[j] <= i_item.op ? i_mat[j][3] : i_mat[3][j];
            end
        end
    end

    // Scale products and sum with translation
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                r_acc[j] <= ACC_W'(r_prod[j][0] >>> FRAC_BITS)
                          + ACC_W'(r_prod[j][1] >>> FRAC_BITS)
                          + ACC_W'(r_prod[j][2] >>> FRAC_BITS)
                          + {{EXT{r_tr[j][DATA_W-1]}}, r_tr[j]};
            end
        end
    end

    // Divide x, y, z by w
    for (genvar g = 0; g < 3; g++) begin : g_div
        hpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  ($signed(r_acc[g])),
            .i_den  ($signed(r_acc[3])),
            .o_quot (quot[g]),
            .o_sat  (sat[g])
        );
    end

    // Carry beat valid and zero-w flag alongside the divider
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wz[0] <= (r_acc[3] == '0);
            for (int s = 0; s < NB; s++) r_wz[s+1] <= r_wz[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s <= NB; s++) r_vd[s] <= 1'b0;
        end else if (en) begin
            r_p1_valid  <= i_avail;
            r_p2_valid  <= r_p1_valid;
            r_vd[0]     <= r_p2_valid;
            for (int s = 0; s < NB; s++) r_vd[s+1] <= r_vd[s];
            r_out_valid <= r_vd[NB];
        end
    end

    // Result register: zero on w of zero, otherwise quotients with status
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) r_out[j] <= r_wz[NB] ? '0 : quot[j];
            if (r_wz[NB])                     r_status <= ST_WZERO;
            else if (sat[0] || sat[1] || sat[2]) r_status <= ST_SAT;
            else                              r_status <= ST_OK;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_out_x  = r_out[0];
    assign o_out_y  = r_out[1];
    assign o_out_z  = r_out[2];
    assign o_status = r_status;

endmodule

// ===== rtl/homogeneous_point_transform_unit.sv =====
// ----------------------------------------------------------------------------
// homogeneous_point_transform_unit
// Transforms a fixed-point 3D point by a 4x4 matrix and divides by w.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry op and point_x/y/z. Output channel:
// o_valid / i_stall carry out_x/y/z and status. A beat moves when valid is
// high and stall is low.
// Matrix: eight 64-bit registers written through i_cfg_we / i_cfg_idx /
// i_cfg_data; write only while no beat is in flight.
// Throughput: one point per cycle while the output is not stalled, set by the
// fully pipelined multipliers and the one-bit-per-stage dividers.
// Path from input beat to result: queue, product, sum, 48 + FRAC_BITS
// divider stages, result register.
// A four-entry queue sits between input and arithmetic; o_stall rises only
// when it is full.
// A stall on a held result freezes the whole arithmetic pipe and holds the result.
// Reset (synchronous) empties the pipe and loads the identity matrix.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_unit #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hpt_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_op,
    input  logic signed [hpt_pkg::DATA_W-1:0] i_point_x,
    input  logic signed [hpt_pkg::DATA_W-1:0] i_point_y,
    input  logic signed [hpt_pkg::DATA_W-1:0] i_point_z,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [hpt_pkg::DATA_W-1:0] o_out_x,
    output logic signed [hpt_pkg::DATA_W-1:0] o_out_y,
    output logic signed [hpt_pkg::DATA_W-1:0] o_out_z,
    output logic [1:0]                      o_status
);
    import hpt_pkg::*;

    localparam t_word ONE = t_word'(1) << FRAC_BITS;

    t_mat  r_mat;
    t_item in_item, q_item;
    logic  q_avail, q_pop;

    // Matrix registers: identity at reset, two entries per write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    r_mat[r][c] <= (r == c) ? ONE : '0;
        end else if (i_cfg_we) begin
            r_mat[i_cfg_idx[2:1]][{i_cfg_idx[0], 1'b0}] <= i_cfg_data[DATA_W-1:0];
            r_mat[i_cfg_idx[2:1]][{i_cfg_idx[0], 1'b1}] <= i_cfg_data[CFG_W-1:DATA_W];
        end
    end

    assign in_item = '{op: i_op, x: i_point_x, y: i_point_y, z: i_point_z};

    hpt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (in_item),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_item  (q_item)
    );

    hpt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mat    (r_mat),
        .i_avail  (q_avail),
        .i_item   (q_item),
        .o_pop    (q_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_out_x  (o_out_x),
        .o_out_y  (o_out_y),
        .o_out_z  (o_out_z),
        .o_status (o_status)
    );

endmodule

// ===== rtl/hpt_checker.sv =====
// ----------------------------------------------------------------------------
// hpt_checker
// Port-level checks on the result channel of the point transform unit.
// ----------------------------------------------------------------------------
`include "homogeneous_point_transform_unit_macros.svh"

module hpt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [hpt_pkg::DATA_W-1:0]  o_out_x,
    input logic [hpt_pkg::DATA_W-1:0]  o_out_y,
    input logic [hpt_pkg::DATA_W-1:0]  o_out_z,
    input logic [1:0]                  o_status
);
    import hpt_pkg::*;

    localparam logic [DATA_W-1:0] MAXV = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MINV = {1'b1, (DATA_W-1)'(0)};

    logic [3*DATA_W+1:0] out_bus;
    logic                clamped;
    logic                zero_pt;

    // Gather the result beat and its clamp and zero conditions
    assign out_bus = {o_out_x, o_out_y, o_out_z, o_status};
    assign clamped = (o_out_x == MAXV) || (o_out_x == MINV) ||
                     (o_out_y == MAXV) || (o_out_y == MINV) ||
                     (o_out_z == MAXV) || (o_out_z == MINV);
    assign zero_pt = (o_out_x == '0) && (o_out_y == '0) && (o_out_z == '0);

    // Reset leaves no result pending
    `HPT_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n, !o_valid)

    // Stalled beat holds
    `HPT_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_bus))

    // Zero w gives a zero point
    `HPT_ASSERT_IMP(a_wzero, i_clk, i_rst_n, o_valid && o_status == ST_WZERO, zero_pt)

    // Saturation shows a clamped coordinate
    `HPT_ASSERT_IMP(a_sat, i_clk, i_rst_n, o_valid && o_status == ST_SAT, clamped)

endmodule

bind homogeneous_point_transform_unit hpt_checker u_hpt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_out_x  (o_out_x),
    .o_out_y  (o_out_y),
    .o_out_z  (o_out_z),
    .o_status (o_status)
);

// ===== tb/sv/homogeneous_point_transform_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point transform checker
// Watches the matrix write port and both channels. Each input beat is
// projected through a local copy of the matrix, and each output beat is
// compared field by field with the oldest projection still waiting.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_unit_checker #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hpt_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    input  logic                              i_stall_in,
    input  logic                              i_op,
    input  logic [hpt_pkg::DATA_W-1:0]        i_point_x,
    input  logic [hpt_pkg::DATA_W-1:0]        i_point_y,
    input  logic [hpt_pkg::DATA_W-1:0]        i_point_z,
    input  logic                              i_out_valid,
    input  logic                              i_stall_out,
    input  logic [hpt_pkg::DATA_W-1:0]        i_out_x,
    input  logic [hpt_pkg::DATA_W-1:0]        i_out_y,
    input  logic [hpt_pkg::DATA_W-1:0]        i_out_z,
    input  logic [1:0]                        i_status,
    output int                                o_pending,
    output int                                o_fail_count
);
    import hpt_pkg::*;

    typedef struct {
        t_word   x;
        t_word   y;
        t_word   z;
        t_status status;
    } t_projection;

    t_mat        mat_q;
    t_projection projections[$];
    int          fail_count;

    assign o_pending    = projections.size();
    assign o_fail_count = fail_count;

    // Product shifted down by the fraction width, kept at accumulator width
    function automatic logic [ACC_W-1:0] scaled_product(t_word a, t_word b);
        logic signed [63:0] p;
        p = $signed(a) * $signed(b);
        return ACC_W'(p >>> FRAC_BITS);
    endfunction

    // Fixed-point quotient truncated toward zero; top bit flags saturation
    function automatic logic [DATA_W:0] fixed_quotient(logic signed [ACC_W-1:0] num,
                                                       logic signed [ACC_W-1:0] den);
        logic signed [63:0] ns, ds;
        logic [63:0]        mn, md, limit;
        logic [127:0]       qq;
        logic               neg;
        logic [31:0]        q;
        ns    = num;
        ds    = den;
        neg   = (ns < 0) != (ds < 0);
        mn    = (ns < 0) ? 64'(-ns) : 64'(ns);
        md    = (ds < 0) ? 64'(-ds) : 64'(ds);
        limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        qq    = ({64'b0, mn} << FRAC_BITS) / {64'b0, md};
        if (qq > {64'b0, limit}) begin
            q = limit[31:0];
            return {1'b1, neg ? -q : q};
        end
        q = qq[31:0];
        return {1'b0, neg ? -q : q};
    endfunction

    function automatic t_projection project(logic op, t_word px, t_word py, t_word pz);
        t_projection      res;
        t_word            pt[3];
        t_word            e;
        logic [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] comp[4];
        logic [DATA_W:0]  qv[3];
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        for (int j = 0; j < 4; j++) begin
            e   = op ? mat_q[j][3] : mat_q[3][j];
            acc = ACC_W'($signed(e));
            for (int k = 0; k < 3; k++) begin
                e   = op ? mat_q[j][k] : mat_q[k][j];
                acc = acc + scaled_product(e, pt[k]);
            end
            comp[j] = acc;
        end
        if (comp[3] == 0) begin
            res.x      = '0;
            res.y      = '0;
            res.z      = '0;
            res.status = ST_WZERO;
            return res;
        end
        for (int j = 0; j < 3; j++)
            qv[j] = fixed_quotient(comp[j], comp[3]);
        res.x      = qv[0][31:0];
        res.y      = qv[1][31:0];
        res.z      = qv[2][31:0];
        res.status = (qv[0][32] | qv[1][32] | qv[2][32]) ? ST_SAT : ST_OK;
        return res;
    endfunction

    initial fail_count = 0;

    always @(posedge i_clk) begin
        t_projection want;
        if (!i_rst_n) begin
            // Load identity and drop anything queued
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    mat_q[r][c] <= (r == c) ? t_word'(1 << FRAC_BITS) : '0;
            projections.delete();
        end else begin
            // Track matrix writes
            if (i_cfg_we) begin
                mat_q[i_cfg_idx[2:1]][{i_cfg_idx[0], 1'b0}] <= i_cfg_data[31:0];
                mat_q[i_cfg_idx[2:1]][{i_cfg_idx[0], 1'b1}] <= i_cfg_data[63:32];
            end
            // Predict on every accepted input beat
            if (i_valid && !i_stall_in)
                projections.push_back(project(i_op, i_point_x, i_point_y, i_point_z));
            // Compare every accepted output beat
            if (i_out_valid && !i_stall_out) begin
                if (projections.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected result x=%h y=%h z=%h status=%0d",
                                 i_out_x, i_out_y, i_out_z, i_status);
                end else begin
                    want = projections.pop_front();
                    if (i_out_x !== want.x || i_out_y !== want.y ||
                        i_out_z !== want.z || i_status !== want.status) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("ERROR: expected x=%h y=%h z=%h status=%0d,",
                                     want.x, want.y, want.z, want.status,
                                     " got x=%h y=%h z=%h status=%0d",
                                     i_out_x, i_out_y, i_out_z, i_status);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/homogeneous_point_transform_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point transform unit test
// Streams directed and random points through the transform unit under a
// series of matrices (identity, random, extreme, zero w) while both sides
// idle at random (but for a last phase with no idling); the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_unit_test;
    import hpt_pkg::*;

    localparam int LATENCY = FRAC_BITS_DEF + 52;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_valid;
    logic              o_stall;
    logic              i_op;
    logic signed [DATA_W-1:0] i_point_x, i_point_y, i_point_z;
    logic              o_valid;
    logic              i_stall;
    logic signed [DATA_W-1:0] o_out_x, o_out_y, o_out_z;
    logic [1:0]        o_status;

    int pending;
    int fail_count;
    int sender_idle_pct;
    int receiver_idle_pct;
    bit hold_off;
    int hold_cycles;

    homogeneous_point_transform_unit u_top (.*);

    homogeneous_point_transform_unit_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_stall_in  (o_stall),
        .i_op        (i_op),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_point_z   (i_point_z),
        .i_out_valid (o_valid),
        .i_stall_out (i_stall),
        .i_out_x     (o_out_x),
        .i_out_y     (o_out_y),
        .i_out_z     (o_out_z),
        .i_status    (o_status),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Receiver stall: random, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_off && hold_cycles < 300) begin
            i_stall     <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end else begin
            if (hold_cycles >= 300)
                hold_off <= 1'b0;
            hold_cycles <= 0;
            i_stall     <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    // Coordinate or matrix entry: mostly moderate, some extremes, some raw
    function automatic t_word pick_word(bit allow_wide);
        int sel;
        sel = $urandom_range(9);
        if (sel < 2) begin
            case ($urandom_range(5))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                4: return 32'h0001_0000;
                default: return 32'hFFFF_0000;
            endcase
        end
        if (sel < 4 && allow_wide)
            return $urandom;
        return t_word'($signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
    endfunction

    task automatic send_point(logic op, t_word x, t_word y, t_word z);
        // Idle each cycle with the sender's idle probability
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_op      <= op;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // Write all eight registers, row by row
    task automatic load_matrix(t_mat m);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= {m[i >> 1][(i & 1) * 2 + 1], m[i >> 1][(i & 1) * 2]};
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_points(int count);
        for (int n = 0; n < count; n++)
            send_point(1'($urandom_range(1)), pick_word(1'b1), pick_word(1'b1),
                       pick_word(1'b1));
    endtask

    function automatic t_mat random_matrix(bit wide);
        t_mat m;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = pick_word(wide);
        // Keep w away from zero in most cases
        m[3][3] = 32'h0001_0000 + ($urandom & 32'h0003_FFFF);
        return m;
    endfunction

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_mat m;
        t_word ext[4];
        ext[0] = 32'h8000_0000;
        ext[1] = 32'h7FFF_FFFF;
        ext[2] = 32'h0000_0000;
        ext[3] = 32'hFFFF_FFFF;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_op = 1'b0; i_point_x = '0; i_point_y = '0; i_point_z = '0;
        i_stall = 1'b0; hold_off = 1'b0; hold_cycles = 0;
        sender_idle_pct = 35;
        receiver_idle_pct = 48;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identity: extremes of each coordinate in both forms
        for (int e = 0; e < 4; e++) begin
            send_point(1'b0, ext[e], ext[3 - e], ext[e]);
            send_point(1'b1, ext[e], ext[e], ext[3 - e]);
        end
        send_point(1'b0, 32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000);
        send_point(1'b1, 32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000);
        random_points(400);
        drain();

        // Random moderate matrix
        load_matrix(random_matrix(1'b0));
        random_points(250);
        drain();

        // Swap idling sides; extreme entries force saturation and wrap
        sender_idle_pct = 48;
        receiver_idle_pct = 35;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = ext[(r + c) & 1];
        load_matrix(m);
        send_point(1'b0, ext[0], ext[1], ext[0]);
        send_point(1'b1, ext[1], ext[1], ext[1]);
        random_points(150);
        drain();

        // Zero w in both forms: last row and last column cleared
        m = random_matrix(1'b1);
        for (int i = 0; i < 4; i++) begin
            m[3][i] = '0;
            m[i][3] = '0;
        end
        load_matrix(m);
        send_point(1'b0, ext[1], ext[0], ext[3]);
        send_point(1'b1, ext[1], ext[0], ext[3]);
        random_points(60);
        drain();

        // Wide random matrix
        load_matrix(random_matrix(1'b1));
        random_points(440);
        drain();

        // No idling; long receiver hold-off to fill the queue
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        load_matrix(random_matrix(1'b0));
        random_points(100);
        hold_off <= 1'b1;
        random_points(240);
        drain();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hpt_pkg.sv
rtl/hpt_front.sv
rtl/hpt_div.sv
rtl/hpt_back.sv
rtl/homogeneous_point_transform_unit.sv
rtl/hpt_checker.sv
tb/sv/homogeneous_point_transform_unit_checker.sv
tb/sv/homogeneous_point_transform_unit_test.sv
